// File: rtl/core/sdc_pkg.sv
// Shared types, codes and defaults for the signal dispatch controller.
package sdc_pkg;

   localparam int MAX_SIGNALS          = 32;
   localparam int DEF_NUM_SIGNALS      = 32;
   localparam int DEF_KILL_SIGNAL      = 9;
   localparam int DEF_STOP_SIGNAL      = 17;
   localparam int DEF_CONT_SIGNAL      = 19;
   localparam int USER_SIG_W           = 5;

   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_RANGE_ERROR = 1'b1;

   typedef enum logic [2:0] {
      OP_POST           = 3'd0,
      OP_DELIVER        = 3'd1,
      OP_RESUME         = 3'd2,
      OP_SET_MASK       = 3'd3,
      OP_SET_ACTION     = 3'd4,
      OP_HANDLER_RETURN = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_DEFAULT = 3'd0,
      KIND_IGNORE  = 3'd1,
      KIND_STOP    = 3'd2,
      KIND_CONT    = 3'd3,
      KIND_KILL    = 3'd4,
      KIND_USER    = 3'd5
   } kind_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [5:0]  signal_number;
      logic [31:0] new_mask;
      logic [2:0]  handler_kind;
      logic [31:0] handler_address;
      logic [31:0] handler_block_mask;
      logic        is_sleeping;
      logic        from_user_mode;
   } req_type;

   typedef struct packed {
      logic                  status;
      logic                  wake_process;
      logic                  stop_applied;
      logic                  cont_applied;
      logic                  kill_applied;
      logic                  user_signal_valid;
      logic [USER_SIG_W-1:0] user_signal;
      logic [31:0]           user_handler_entry;
      logic [31:0]           old_value;
      logic [31:0]           old_entry_address;
      logic [2:0]            old_kind;
      logic                  resumed;
   } rsp_type;

   // one bit per signal for each action kind
   typedef struct packed {
      logic [MAX_SIGNALS-1:0] dfl;
      logic [MAX_SIGNALS-1:0] ign;
      logic [MAX_SIGNALS-1:0] stop;
      logic [MAX_SIGNALS-1:0] cont;
      logic [MAX_SIGNALS-1:0] kill;
      logic [MAX_SIGNALS-1:0] user;
   } kind_class_type;

   typedef struct packed {
      logic [MAX_SIGNALS-1:0] applied;
      logic                   user_found;
      logic [USER_SIG_W-1:0]  user_index;
      logic                   stop_hit;
      logic                   cont_hit;
      logic                   kill_hit;
      logic                   stop_last;
      logic                   resume_found;
      logic [MAX_SIGNALS-1:0] resume_bit;
   } scan_type;

endpackage

// File: rtl/core/sdc_action_table.sv
// Per-signal action table: kind, handler address and handler mask.
module sdc_action_table
   import sdc_pkg::*;
#(
   parameter int NUM_SIGNALS = DEF_NUM_SIGNALS,
   localparam int IDX_W = $clog2(NUM_SIGNALS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_index,
   input  kind_type         wr_kind,
   input  logic [31:0]      wr_address,
   input  logic [31:0]      wr_mask,
   input  logic [IDX_W-1:0] rd_index,
   output kind_type         rd_kind,
   output logic [31:0]      rd_address,
   output logic [31:0]      rd_mask,
   output kind_class_type   classes
);

   logic [NUM_SIGNALS-1:0] valid_ff;
   logic [NUM_SIGNALS-1:0] valid_in;
   kind_type               kind_ff    [NUM_SIGNALS];
   logic [31:0]            address_ff [NUM_SIGNALS];
   logic [31:0]            mask_ff    [NUM_SIGNALS];

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_index] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         kind_ff[wr_index]    <= wr_kind;
         address_ff[wr_index] <= wr_address;
         mask_ff[wr_index]    <= wr_mask;
      end
   end

   // never-written entries read as the reset action
   assign rd_kind    = valid_ff[rd_index] ? kind_ff[rd_index] : KIND_DEFAULT;
   assign rd_address = valid_ff[rd_index] ? address_ff[rd_index] : 32'd0;
   assign rd_mask    = valid_ff[rd_index] ? mask_ff[rd_index] : 32'd0;

   always_comb begin
      classes = '0;
      for (int i = 0; i < NUM_SIGNALS; i++) begin
         if (!valid_ff[i]) begin
            classes.dfl[i] = 1'b1;
         end else begin
            classes.dfl[i]  = (kind_ff[i] == KIND_DEFAULT);
            classes.ign[i]  = (kind_ff[i] == KIND_IGNORE);
            classes.stop[i] = (kind_ff[i] == KIND_STOP);
            classes.cont[i] = (kind_ff[i] == KIND_CONT);
            classes.kill[i] = (kind_ff[i] == KIND_KILL);
            classes.user[i] = (kind_ff[i] == KIND_USER);
         end
      end
   end

endmodule

// File: rtl/core/sdc_signal_scan.sv
// Parallel pick over pending signals for deliver and resume check.
module sdc_signal_scan
   import sdc_pkg::*;
#(
   parameter int NUM_SIGNALS = DEF_NUM_SIGNALS,
   parameter int KILL_SIGNAL = DEF_KILL_SIGNAL,
   parameter int STOP_SIGNAL = DEF_STOP_SIGNAL,
   parameter int CONT_SIGNAL = DEF_CONT_SIGNAL
) (
   input  logic [MAX_SIGNALS-1:0] pending,
   input  logic [MAX_SIGNALS-1:0] block_mask,
   input  kind_class_type         classes,
   output scan_type               scan
);

   logic [MAX_SIGNALS-1:0] elig;
   logic [MAX_SIGNALS-1:0] stop_c;
   logic [MAX_SIGNALS-1:0] cont_c;
   logic [MAX_SIGNALS-1:0] kill_c;
   logic [MAX_SIGNALS-1:0] user_c;
   logic [MAX_SIGNALS-1:0] resume_c;
   logic [MAX_SIGNALS-1:0] user_first;
   logic [MAX_SIGNALS-1:0] upto;
   logic [MAX_SIGNALS-1:0] applied;
   logic [MAX_SIGNALS-1:0] stop_a;
   logic [MAX_SIGNALS-1:0] cont_a;
   logic [MAX_SIGNALS-1:0] smear1;
   logic [MAX_SIGNALS-1:0] smear2;
   logic [MAX_SIGNALS-1:0] smear4;
   logic [MAX_SIGNALS-1:0] smear8;
   logic [MAX_SIGNALS-1:0] smear16;
   logic [USER_SIG_W-1:0]  user_index;

   always_comb begin
      elig     = '0;
      stop_c   = '0;
      cont_c   = '0;
      kill_c   = '0;
      user_c   = '0;
      resume_c = '0;
      for (int i = 0; i < NUM_SIGNALS; i++) begin
         if (i == KILL_SIGNAL) begin
            elig[i]   = pending[i];
            kill_c[i] = 1'b1;
         end else if (i == STOP_SIGNAL) begin
            elig[i]   = pending[i];
            stop_c[i] = 1'b1;
         end else begin
            elig[i]   = pending[i] && !block_mask[i] && !classes.ign[i];
            stop_c[i] = classes.stop[i];
            cont_c[i] = classes.cont[i] || ((i == CONT_SIGNAL) && classes.dfl[i]);
            kill_c[i] = !cont_c[i] && (classes.kill[i] || classes.dfl[i]);
            user_c[i] = classes.user[i];
         end
         resume_c[i] = pending[i] && !block_mask[i] &&
                       (classes.cont[i] || ((i == CONT_SIGNAL) && classes.dfl[i]));
      end
   end

   // every eligible signal up to and including the first user-handled one is applied; all of them if none is
   assign user_first = (elig & user_c) & (~(elig & user_c) + 32'd1);
   assign upto       = user_first | (user_first - 32'd1);
   assign applied    = elig & upto;
   assign stop_a     = applied & stop_c;
   assign cont_a     = applied & cont_c;

   // stop wins when it sits above every applied continue
   assign smear1  = cont_a | (cont_a >> 1);
   assign smear2  = smear1 | (smear1 >> 2);
   assign smear4  = smear2 | (smear2 >> 4);
   assign smear8  = smear4 | (smear4 >> 8);
   assign smear16 = smear8 | (smear8 >> 16);

   always_comb begin
      user_index = '0;
      for (int i = 0; i < MAX_SIGNALS; i++) begin
         if (user_first[i]) begin
            user_index = user_index | USER_SIG_W'(i);
         end
      end
   end

   always_comb begin
      scan              = '0;
      scan.applied      = applied;
      scan.user_found   = |user_first;
      scan.user_index   = user_index;
      scan.stop_hit     = |stop_a;
      scan.cont_hit     = |cont_a;
      scan.kill_hit     = |(applied & kill_c);
      scan.stop_last    = |(stop_a & ~smear16);
      scan.resume_found = |resume_c;
      scan.resume_bit   = resume_c & (~resume_c + 32'd1);
   end

endmodule

// File: rtl/core/signal_dispatch_controller.sv
// Signal dispatch controller top level: input register, state, result register.
//
// One transaction is taken per clock while busy is low; busy is high only during
// reset and the first cycle after it. Each transaction gives exactly one result,
// shown on the rsp_ ports for one cycle with rsp_strobe high, starting at the clock
// edge after acceptance, in order. There is no back-pressure: the receiver must take
// every result when it is strobed. Latency and the one-per-clock rate are set by the
// single pass from the input register through the signal scan and the action
// table read into the result register; all state updates land on that same edge,
// so the next transaction sees them.
module signal_dispatch_controller
   import sdc_pkg::*;
#(
   parameter int NUM_SIGNALS = DEF_NUM_SIGNALS,
   parameter int KILL_SIGNAL = DEF_KILL_SIGNAL,
   parameter int STOP_SIGNAL = DEF_STOP_SIGNAL,
   parameter int CONT_SIGNAL = DEF_CONT_SIGNAL
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int IDX_W = $clog2(NUM_SIGNALS);

   logic                   busy_ff;
   logic                   req_valid_ff;
   req_type                req_ff;
   logic                   rsp_strobe_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   logic [MAX_SIGNALS-1:0] pending_ff;
   logic [MAX_SIGNALS-1:0] pending_in;
   logic [31:0]            block_mask_ff;
   logic [31:0]            block_mask_in;
   logic [31:0]            saved_mask_ff;
   logic [31:0]            saved_mask_in;
   logic                   frozen_ff;
   logic                   frozen_in;
   logic                   killed_ff;
   logic                   killed_in;

   logic                   wr_en;
   kind_type               wr_kind;
   logic [IDX_W-1:0]       sig_idx;
   logic [IDX_W-1:0]       rd_index;
   kind_type               rd_kind;
   logic [31:0]            rd_address;
   logic [31:0]            rd_mask;
   kind_class_type         classes;
   scan_type               scan;
   logic                   sig_in_range;
   logic                   sig_is_kill;
   logic [MAX_SIGNALS-1:0] sig_bit;

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   assign sig_in_range = (req_ff.signal_number < 6'(NUM_SIGNALS));
   assign sig_is_kill  = (req_ff.signal_number == 6'(KILL_SIGNAL));
   assign sig_idx      = req_ff.signal_number[IDX_W-1:0];
   assign sig_bit      = 32'd1 << sig_idx;
   assign rd_index     = (req_ff.opcode == OP_DELIVER) ? scan.user_index[IDX_W-1:0] : sig_idx;
   assign wr_kind      = (req_ff.handler_kind > KIND_USER) ? KIND_DEFAULT
                                                           : kind_type'(req_ff.handler_kind);

   sdc_action_table #(
      .NUM_SIGNALS (NUM_SIGNALS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_index   (sig_idx),
      .wr_kind    (wr_kind),
      .wr_address (req_ff.handler_address),
      .wr_mask    (req_ff.handler_block_mask),
      .rd_index   (rd_index),
      .rd_kind    (rd_kind),
      .rd_address (rd_address),
      .rd_mask    (rd_mask),
      .classes    (classes)
   );

   sdc_signal_scan #(
      .NUM_SIGNALS (NUM_SIGNALS),
      .KILL_SIGNAL (KILL_SIGNAL),
      .STOP_SIGNAL (STOP_SIGNAL),
      .CONT_SIGNAL (CONT_SIGNAL)
   ) u_scan (
      .pending    (pending_ff),
      .block_mask (block_mask_ff),
      .classes    (classes),
      .scan       (scan)
   );

   always_comb begin
      rsp_in        = '0;
      pending_in    = pending_ff;
      block_mask_in = block_mask_ff;
      saved_mask_in = saved_mask_ff;
      frozen_in     = frozen_ff;
      killed_in     = killed_ff;
      wr_en         = 1'b0;
      if (req_valid_ff) begin
         case (req_ff.opcode)
            OP_POST: begin
               if (!sig_in_range) begin
                  rsp_in.status = STATUS_RANGE_ERROR;
               end else if (rd_kind != KIND_IGNORE || sig_is_kill) begin
                  pending_in          = pending_ff | sig_bit;
                  rsp_in.wake_process = req_ff.is_sleeping &&
                                        (sig_is_kill ||
                                         (((block_mask_ff & sig_bit) == '0) &&
                                          (rd_kind == KIND_KILL || rd_kind == KIND_DEFAULT)));
               end
            end
            OP_DELIVER: begin
               if (req_ff.from_user_mode && !killed_ff) begin
                  pending_in          = pending_ff & ~scan.applied;
                  rsp_in.stop_applied = scan.stop_hit;
                  rsp_in.cont_applied = scan.cont_hit;
                  rsp_in.kill_applied = scan.kill_hit;
                  if (scan.kill_hit) begin
                     killed_in = 1'b1;
                  end
                  if (scan.stop_hit || scan.cont_hit) begin
                     frozen_in = scan.stop_last;
                  end
                  if (scan.user_found) begin
                     saved_mask_in             = block_mask_ff;
                     block_mask_in             = rd_mask;
                     rsp_in.user_signal_valid  = 1'b1;
                     rsp_in.user_signal        = scan.user_index;
                     rsp_in.user_handler_entry = rd_address;
                  end
               end
            end
            OP_RESUME: begin
               if (frozen_ff && scan.resume_found) begin
                  pending_in     = pending_ff & ~scan.resume_bit;
                  frozen_in      = 1'b0;
                  rsp_in.resumed = 1'b1;
               end
            end
            OP_SET_MASK: begin
               rsp_in.old_value = block_mask_ff;
               block_mask_in    = req_ff.new_mask;
            end
            OP_SET_ACTION: begin
               if (!sig_in_range) begin
                  rsp_in.status = STATUS_RANGE_ERROR;
               end else begin
                  rsp_in.old_value         = rd_mask;
                  rsp_in.old_entry_address = rd_address;
                  rsp_in.old_kind          = rd_kind;
                  wr_en                    = 1'b1;
               end
            end
            OP_HANDLER_RETURN: begin
               block_mask_in = saved_mask_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         pending_ff    <= '0;
         block_mask_ff <= '0;
         saved_mask_ff <= '0;
         frozen_ff     <= 1'b0;
         killed_ff     <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         req_valid_ff  <= start && !busy_ff;
         rsp_strobe_ff <= req_valid_ff;
         pending_ff    <= pending_in;
         block_mask_ff <= block_mask_in;
         saved_mask_ff <= saved_mask_in;
         frozen_ff     <= frozen_in;
         killed_ff     <= killed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         req_ff <= req_item;
      end
      rsp_ff <= rsp_in;
   end

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> rsp_strobe_ff)
      else $error("accepted transaction gave no result strobe");

   a_killed_sticks: assert property (@(posedge clock) disable iff (reset)
      killed_ff |=> killed_ff)
      else $error("killed flag cleared");

   a_pending_range: assert property (@(posedge clock) disable iff (reset)
      (pending_ff >> NUM_SIGNALS) == '0)
      else $error("pending bit above signal count");

   a_handler_saves_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.user_signal_valid) |-> (saved_mask_ff == $past(block_mask_ff)))
      else $error("handler entry did not save block mask");

   a_range_no_wake: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.status == STATUS_RANGE_ERROR) |->
         (!rsp_ff.wake_process && pending_ff == $past(pending_ff)))
      else $error("rejected signal changed pending set");

endmodule
